### rtl/core/srn_pkg.sv
`default_nettype none

package srn_pkg;

   // sample and intermediate widths, all exact for signed q4.12 inputs
   localparam int unsigned SAMPLE_WIDTH  = 16;
   localparam int unsigned ROW_COUNT     = 3;
   localparam int unsigned PROD_WIDTH    = 2 * SAMPLE_WIDTH;
   localparam int unsigned PAIR_WIDTH    = PROD_WIDTH + 1;
   localparam int unsigned DOT_WIDTH     = PROD_WIDTH + 2;
   localparam int unsigned SQFULL_WIDTH  = 2 * DOT_WIDTH;
   localparam int unsigned SQUARE_WIDTH  = SQFULL_WIDTH - 2;
   localparam int unsigned NORM_WIDTH    = 43;
   localparam int unsigned NORM_SHIFT    = 26;
   localparam int unsigned ACC_WIDTH     = NORM_WIDTH + NORM_SHIFT;

   localparam int unsigned REQ_TDATA_WIDTH = 2 * ROW_COUNT * SAMPLE_WIDTH;
   localparam int unsigned RSP_TDATA_WIDTH = ((NORM_WIDTH + 7) / 8) * 8;

   // lanes 0..2 are the diagonal terms, 3..5 the symmetrised cross terms
   localparam int unsigned LANE_COUNT = 6;
   localparam int unsigned PART_COUNT = 3;
   localparam int unsigned LANE_X [LANE_COUNT] = '{0, 1, 2, 0, 0, 1};
   localparam int unsigned LANE_Y [LANE_COUNT] = '{0, 1, 2, 1, 2, 2};

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef sample_type [ROW_COUNT-1:0]     column_type;
   typedef logic [SQUARE_WIDTH-1:0]        square_type;
   typedef logic [NORM_WIDTH-1:0]          norm_type;

endpackage

`default_nettype wire

### rtl/core/srn_lane.sv
`default_nettype none

module srn_lane
   import srn_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       advance,
   input  wire column_type grad_x,
   input  wire column_type velgrad_x,
   input  wire column_type grad_y,
   input  wire column_type velgrad_y,
   output square_type      square
);

   // s = grad_x . velgrad_y + grad_y . velgrad_x, then s squared
   logic signed [PROD_WIDTH-1:0]   prod_in [2*ROW_COUNT];
   logic signed [PROD_WIDTH-1:0]   prod_ff [2*ROW_COUNT];
   logic signed [PAIR_WIDTH-1:0]   pair_in [ROW_COUNT];
   logic signed [PAIR_WIDTH-1:0]   pair_ff [ROW_COUNT];
   logic signed [DOT_WIDTH-1:0]    dot_in;
   logic signed [DOT_WIDTH-1:0]    dot_ff;
   logic signed [SQFULL_WIDTH-1:0] square_full;
   square_type                     square_in;
   square_type                     square_ff;

   always_comb begin
      for (int r = 0; r < ROW_COUNT; r++) begin
         prod_in[r]             = $signed(grad_x[r]) * $signed(velgrad_y[r]);
         prod_in[r + ROW_COUNT] = $signed(grad_y[r]) * $signed(velgrad_x[r]);
         pair_in[r] = PAIR_WIDTH'(prod_ff[r]) + PAIR_WIDTH'(prod_ff[r + ROW_COUNT]);
      end
      dot_in = DOT_WIDTH'(pair_ff[0]) + DOT_WIDTH'(pair_ff[1]) + DOT_WIDTH'(pair_ff[2]);
      square_full = dot_ff * dot_ff;
      square_in   = square_full[SQUARE_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff   <= prod_in;
         pair_ff   <= pair_in;
         dot_ff    <= dot_in;
         square_ff <= square_in;
      end
   end

   assign square = square_ff;

endmodule

`default_nettype wire

### rtl/core/srn_merge.sv
`default_nettype none

module srn_merge
   import srn_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       advance,
   input  wire square_type square [LANE_COUNT],
   output norm_type        norm_squared
);

   // diagonal lanes carry (2d)^2, cross lanes c^2: sum diag + 2 * cross, drop 26 bits
   logic [ACC_WIDTH-1:0] part_in [PART_COUNT];
   logic [ACC_WIDTH-1:0] part_ff [PART_COUNT];
   logic [ACC_WIDTH-1:0] total;
   norm_type             norm_ff;

   always_comb begin
      part_in[0] = ACC_WIDTH'(square[0]) + ACC_WIDTH'(square[1]);
      part_in[1] = ACC_WIDTH'(square[2]) + (ACC_WIDTH'(square[3]) << 1);
      part_in[2] = (ACC_WIDTH'(square[4]) << 1) + (ACC_WIDTH'(square[5]) << 1);
      total      = part_ff[0] + part_ff[1] + part_ff[2];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         part_ff <= part_in;
         norm_ff <= total[ACC_WIDTH-1:NORM_SHIFT];
      end
   end

   assign norm_squared = norm_ff;

endmodule

`default_nettype wire

### rtl/core/strain_rate_norm_squared_3d_top.sv
`default_nettype none

// channel   dir  word carries                              accepted when
// req_      in   one column of grad and velgrad (6 rows)   req_tvalid & req_tready
// rsp_      out  squared strain rate norm, 24 frac bits    rsp_tvalid & rsp_tready
//
// three req words make one element (columns 1, 2, 3 in order); the third starts
// the lanes. one word a cycle while rsp keeps up, one element per three words;
// the six-lane multiply pipeline registers products, pair sums, dot and square,
// then the merge registers part sums and the norm before the result shows on rsp.
// reset (synchronous, active high) empties the pipeline and restarts at column 1.
// while a result waits untaken the whole pipeline holds and req_tready is low.

module strain_rate_norm_squared_3d_top
   import srn_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   // grad_row1, grad_row2, grad_row3, velgrad_row1, velgrad_row2, velgrad_row3
   input  wire logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   // norm_squared, then zero padding
   output logic [RSP_TDATA_WIDTH-1:0]      rsp_tdata
);

   localparam int unsigned PIPE_DEPTH = 5;

   logic                  advance;
   logic                  req_accept;
   logic                  launch;
   logic [1:0]            column_count_ff;
   logic [1:0]            column_count_in;
   logic [PIPE_DEPTH-1:0] valid_ff;
   logic [PIPE_DEPTH-1:0] valid_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;

   column_type            in_grad;
   column_type            in_velgrad;
   column_type            held_grad_ff [2];
   column_type            held_velgrad_ff [2];
   column_type            grad_col [ROW_COUNT];
   column_type            velgrad_col [ROW_COUNT];
   square_type            lane_square [LANE_COUNT];
   norm_type              norm_squared;

   // whole pipeline moves together; only a waiting result holds it
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign req_accept = req_tvalid && req_tready;
   // count three is treated as the third column
   assign launch     = req_accept && column_count_ff[1];

   // unpack the word, row 1 lowest
   always_comb begin
      for (int r = 0; r < ROW_COUNT; r++) begin
         in_grad[r]    = req_tdata[r * SAMPLE_WIDTH +: SAMPLE_WIDTH];
         in_velgrad[r] = req_tdata[(ROW_COUNT + r) * SAMPLE_WIDTH +: SAMPLE_WIDTH];
      end
   end

   // columns 1 and 2 come from the hold registers, column 3 straight from the word
   always_comb begin
      grad_col[0]    = held_grad_ff[0];
      grad_col[1]    = held_grad_ff[1];
      grad_col[2]    = in_grad;
      velgrad_col[0] = held_velgrad_ff[0];
      velgrad_col[1] = held_velgrad_ff[1];
      velgrad_col[2] = in_velgrad;
   end

   always_comb begin
      column_count_in = column_count_ff;
      if (req_accept) begin
         if (column_count_ff[1]) begin
            column_count_in = 2'd0;
         end else begin
            column_count_in = column_count_ff + 2'd1;
         end
      end
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         valid_in     = {valid_ff[PIPE_DEPTH-2:0], launch};
         rsp_valid_in = valid_ff[PIPE_DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= 2'd0;
         valid_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         column_count_ff <= column_count_in;
         valid_ff        <= valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // hold registers for columns 1 and 2, payload only
   always_ff @(posedge clock) begin
      if (req_accept && !column_count_ff[1]) begin
         held_grad_ff[column_count_ff[0]]    <= in_grad;
         held_velgrad_ff[column_count_ff[0]] <= in_velgrad;
      end
   end

   // one lane per distinct entry of the symmetric strain rate
   for (genvar i = 0; i < LANE_COUNT; i++) begin : g_lane
      srn_lane u_lane (
         .clock     (clock),
         .advance   (advance),
         .grad_x    (grad_col[LANE_X[i]]),
         .velgrad_x (velgrad_col[LANE_X[i]]),
         .grad_y    (grad_col[LANE_Y[i]]),
         .velgrad_y (velgrad_col[LANE_Y[i]]),
         .square    (lane_square[i])
      );
   end

   srn_merge u_merge (
      .clock        (clock),
      .advance      (advance),
      .square       (lane_square),
      .norm_squared (norm_squared)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_WIDTH'(norm_squared);

endmodule

`default_nettype wire
